@@ rtl/core/swst_pkg.sv @@
// Shared types, constants and outcome codes for the stop-and-wait sender table.
package swst_pkg;

  // Slots that the fixed-width index fields can reach.
  localparam int QUEUE_SLOTS = 4;
  localparam int PEER_SLOTS  = 8;

  // Default table dimensions.
  localparam int DEF_NUM_QUEUES = 4;
  localparam int DEF_NUM_PEERS  = 8;

  // Field widths.
  localparam int SEQ_BITS   = 32;
  localparam int TIME_BITS  = 32;
  localparam int RTT_BITS   = 16;
  localparam int RETRY_BITS = 8;

  localparam logic [RETRY_BITS-1:0] RETRY_LIMIT_RST = 8'd3;

  typedef logic [SEQ_BITS-1:0]   seq_t;
  typedef logic [TIME_BITS-1:0]  tstamp_t;
  typedef logic [RETRY_BITS-1:0] retry_t;

  typedef enum logic [2:0] {
    OC_NOTHING = 3'd0,
    OC_WAIT    = 3'd1,
    OC_NEXT    = 3'd2,
    OC_RETX    = 3'd3,
    OC_DOWN    = 3'd4,
    OC_SKIP    = 3'd5
  } outcome_t;

  // One input transaction.
  typedef struct packed {
    logic                action;
    logic [1:0]          queue_index;
    logic [2:0]          member_index;
    logic                newest_valid;
    seq_t                newest_seqno;
    logic                ack_valid;
    seq_t                ack_seqno;
    logic [RTT_BITS-1:0] round_trip;
    tstamp_t             now_ms;
  } item_t;

  // One result transaction.
  typedef struct packed {
    outcome_t outcome;
    seq_t     tx_seqno;
    retry_t   retries_now;
  } result_t;

  // Per-pair entry held in the state memory.
  typedef struct packed {
    seq_t    seq;
    tstamp_t stamp;
    retry_t  retries;
  } pair_entry_t;

  // State updates requested by the decision logic.
  typedef struct packed {
    logic entry_we;
    logic down_set;
    logic down_clr;
  } upd_t;

endpackage

@@ rtl/core/swst_if.sv @@
// Valid/ready channel interfaces for the check items and the results.
interface swst_in_if;
  import swst_pkg::*;

  logic                valid;
  logic                ready;
  logic                action;
  logic [1:0]          queue_index;
  logic [2:0]          member_index;
  logic                newest_valid;
  seq_t                newest_seqno;
  logic                ack_valid;
  seq_t                ack_seqno;
  logic [RTT_BITS-1:0] round_trip;
  tstamp_t             now_ms;

  modport source (
    output valid, action, queue_index, member_index, newest_valid, newest_seqno,
           ack_valid, ack_seqno, round_trip, now_ms,
    input  ready
  );

  modport sink (
    input  valid, action, queue_index, member_index, newest_valid, newest_seqno,
           ack_valid, ack_seqno, round_trip, now_ms,
    output ready
  );
endinterface

interface swst_out_if;
  import swst_pkg::*;

  logic       valid;
  logic       ready;
  logic [2:0] outcome;
  seq_t       tx_seqno;
  retry_t     retries_now;

  modport source (
    output valid, outcome, tx_seqno, retries_now,
    input  ready
  );

  modport sink (
    input  valid, outcome, tx_seqno, retries_now,
    output ready
  );
endinterface

@@ rtl/core/swst_decide.sv @@
// Decision logic: picks the outcome for one transaction and the state updates it causes.
module swst_decide (
  input  swst_pkg::item_t       item,
  input  logic                  in_range,
  input  logic                  in_peer,
  input  logic                  entry_valid,
  input  swst_pkg::pair_entry_t entry,
  input  logic                  peer_is_down,
  input  swst_pkg::retry_t      retry_limit,
  output swst_pkg::result_t     res,
  output swst_pkg::pair_entry_t wr_entry,
  output swst_pkg::upd_t        upd
);
  import swst_pkg::*;

  logic    acked;
  seq_t    next_seq;
  tstamp_t elapsed;
  tstamp_t wait_lim;
  retry_t  sat_retry;
  retry_t  retx_retry;

  // Compares and arithmetic shared by the decision below.
  assign acked      = entry_valid && item.ack_valid && (entry.seq == item.ack_seqno);
  assign next_seq   = entry_valid ? entry.seq + seq_t'(1) : '0;
  assign elapsed    = item.now_ms - entry.stamp;
  assign wait_lim   = {{(TIME_BITS-RTT_BITS-1){1'b0}}, item.round_trip, 1'b0};
  assign sat_retry  = (entry.retries == '1) ? entry.retries : entry.retries + retry_t'(1);
  // A resend after the queue fell behind an acknowledged number keeps the count.
  assign retx_retry = acked ? entry.retries : sat_retry;

  // Priority chain of the stop-and-wait decision.
  always_comb begin
    res      = '{outcome: OC_NOTHING, tx_seqno: '0, retries_now: '0};
    wr_entry = entry;
    upd      = '0;
    if (item.action) begin
      upd.down_clr = in_peer;
    end else if (!in_range) begin
      res.outcome = OC_SKIP;
    end else if (peer_is_down) begin
      res.outcome     = OC_SKIP;
      res.retries_now = entry.retries;
    end else if (!item.newest_valid) begin
      res.retries_now = entry.retries;
    end else if (acked && entry.seq == item.newest_seqno) begin
      res.retries_now = entry.retries;
    end else if (!entry_valid || (acked && entry.seq < item.newest_seqno)) begin
      wr_entry     = '{seq: next_seq, stamp: item.now_ms, retries: '0};
      upd.entry_we = 1'b1;
      res.outcome  = OC_NEXT;
      res.tx_seqno = next_seq;
    end else if (!acked && elapsed < wait_lim) begin
      res.outcome     = OC_WAIT;
      res.retries_now = entry.retries;
    end else if (!acked && entry.retries > retry_limit) begin
      wr_entry.retries = '0;
      upd.entry_we     = 1'b1;
      upd.down_set     = 1'b1;
      res.outcome      = OC_DOWN;
    end else begin
      wr_entry.stamp   = item.now_ms;
      wr_entry.retries = retx_retry;
      upd.entry_we     = 1'b1;
      res.outcome      = OC_RETX;
      res.tx_seqno     = entry.seq;
      res.retries_now  = retx_retry;
    end
  end

endmodule

@@ rtl/core/stop_and_wait_sender_table.sv @@
// Top level of the stop-and-wait sender table: pair state memory, forwarding and handshakes.
//
//   Channel   Direction  Handshake           Carries
//   item      in         valid/ready         check or reconnect transaction
//   result    out        valid/ready         outcome, tx_seqno, retries_now
//   cfg       in         cfg_wr_en, no wait  retry_limit
//
// One transaction per cycle sustained while results are taken; it passes the decision stage
// registers, then the result register. The rate is set by the pair memory: one read at
// acceptance, one write back from the decision stage, with the last write forwarded when the
// next transaction hits the same pair. Reset clears control, per-pair valid bits and down
// flags; no clearing pass. A stalled result holds the decision stage, so item.ready drops.
module stop_and_wait_sender_table #(
  parameter int NUM_QUEUES = swst_pkg::DEF_NUM_QUEUES,
  parameter int NUM_PEERS  = swst_pkg::DEF_NUM_PEERS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [swst_pkg::RETRY_BITS-1:0] cfg_wr_data,
  swst_in_if.sink                    item,
  swst_out_if.source                 result
);
  import swst_pkg::*;

  localparam int Q_USED    = (NUM_QUEUES < QUEUE_SLOTS) ? NUM_QUEUES : QUEUE_SLOTS;
  localparam int P_USED    = (NUM_PEERS < PEER_SLOTS) ? NUM_PEERS : PEER_SLOTS;
  localparam int NUM_PAIRS = Q_USED * P_USED;
  localparam int PAIR_W    = (NUM_PAIRS > 1) ? $clog2(NUM_PAIRS) : 1;
  localparam int PEER_W    = (P_USED > 1) ? $clog2(P_USED) : 1;

  item_t             in_item;
  logic              in_acc;
  logic              in_range;
  logic              in_peer;
  logic [PAIR_W-1:0] rd_pair;

  logic              s1_valid;
  item_t             s1_item;
  logic [PAIR_W-1:0] s1_pair;
  logic              s1_in_range;
  logic              s1_in_peer;
  logic              out_free;
  logic              s1_fire;
  logic              wr_fire;

  pair_entry_t       pair_mem [NUM_PAIRS];
  pair_entry_t       rd_entry;
  logic [NUM_PAIRS-1:0] pair_valid;
  logic              fwd_valid;
  logic [PAIR_W-1:0] fwd_pair;
  pair_entry_t       fwd_entry;

  logic [P_USED-1:0] peer_down;
  logic [PEER_W-1:0] s1_peer;
  retry_t            retry_limit;

  logic              cur_valid;
  pair_entry_t       cur_entry;
  logic              peer_is_down;
  result_t           dec_res;
  pair_entry_t       wr_entry;
  upd_t              upd;

  logic              res_valid;
  result_t           res_data;

  // Gather the incoming transaction and locate its pair.
  assign in_item = '{
    action:       item.action,
    queue_index:  item.queue_index,
    member_index: item.member_index,
    newest_valid: item.newest_valid,
    newest_seqno: item.newest_seqno,
    ack_valid:    item.ack_valid,
    ack_seqno:    item.ack_seqno,
    round_trip:   item.round_trip,
    now_ms:       item.now_ms
  };
  assign in_peer  = int'(item.member_index) < P_USED;
  assign in_range = (int'(item.queue_index) < Q_USED) && in_peer;
  assign rd_pair  = in_range ?
                    PAIR_W'(int'(item.queue_index) * P_USED + int'(item.member_index)) : '0;

  // Handshake control: the decision stage moves whenever the result register is free.
  assign out_free   = !res_valid || result.ready;
  assign s1_fire    = s1_valid && out_free;
  assign item.ready = !s1_valid || out_free;
  assign in_acc     = item.valid && item.ready;
  assign wr_fire    = s1_fire && upd.entry_we;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      retry_limit <= RETRY_LIMIT_RST;
    end else if (cfg_wr_en) begin
      retry_limit <= cfg_wr_data;
    end
  end

  // Decision stage registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item     <= in_item;
      s1_pair     <= rd_pair;
      s1_in_range <= in_range;
      s1_in_peer  <= in_peer;
    end
  end

  // Pair state memory: read at acceptance, written back from the decision stage.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_entry <= pair_mem[rd_pair];
    end
    if (wr_fire) begin
      pair_mem[s1_pair] <= wr_entry;
    end
  end

  // Last write, forwarded to a read that raced it.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (wr_fire) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_fire) begin
      fwd_pair  <= s1_pair;
      fwd_entry <= wr_entry;
    end
  end

  // Per-pair valid bits: an entry never written reads as all zeros.
  always_ff @(posedge clk) begin
    if (rst) begin
      pair_valid <= '0;
    end else if (wr_fire) begin
      pair_valid[s1_pair] <= 1'b1;
    end
  end

  // Per-peer down flags.
  assign s1_peer = s1_item.member_index[PEER_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      peer_down <= '0;
    end else if (s1_fire) begin
      if (upd.down_set) begin
        peer_down[s1_peer] <= 1'b1;
      end else if (upd.down_clr) begin
        peer_down[s1_peer] <= 1'b0;
      end
    end
  end

  // Current view of the pair: zeros if unwritten, else the newest copy.
  always_comb begin
    cur_valid    = s1_in_range && pair_valid[s1_pair];
    peer_is_down = s1_in_range && peer_down[s1_peer];
    if (!cur_valid) begin
      cur_entry = '0;
    end else if (fwd_valid && fwd_pair == s1_pair) begin
      cur_entry = fwd_entry;
    end else begin
      cur_entry = rd_entry;
    end
  end

  swst_decide u_decide (
    .item         (s1_item),
    .in_range     (s1_in_range),
    .in_peer      (s1_in_peer),
    .entry_valid  (cur_valid),
    .entry        (cur_entry),
    .peer_is_down (peer_is_down),
    .retry_limit  (retry_limit),
    .res          (dec_res),
    .wr_entry     (wr_entry),
    .upd          (upd)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_fire) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      res_data <= dec_res;
    end
  end

  assign result.valid       = res_valid;
  assign result.outcome     = res_data.outcome;
  assign result.tx_seqno    = res_data.tx_seqno;
  assign result.retries_now = res_data.retries_now;

endmodule

@@ rtl/core/swst_chk.sv @@
// Port-level checker for the stop-and-wait sender table, bound to the top level.
module swst_chk (
  input logic                     clk,
  input logic                     rst,
  input logic                     res_valid,
  input logic                     res_ready,
  input logic [2:0]               outcome,
  input swst_pkg::seq_t           tx_seqno,
  input swst_pkg::retry_t         retries_now
);
  import swst_pkg::*;

  // A result left waiting keeps its contents.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(outcome) && $stable(tx_seqno)
                               && $stable(retries_now))
    else $error("result changed while stalled");

  // Reset leaves no result pending.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  // Only a send or a resend names a sequence number.
  a_seq_only_on_send: assert property (@(posedge clk) disable iff (rst)
    res_valid && outcome != OC_NEXT && outcome != OC_RETX |-> tx_seqno == '0)
    else $error("sequence number on a result that sends nothing");

  // A fresh send and a peer-down decision both clear the retry count.
  a_retry_cleared: assert property (@(posedge clk) disable iff (rst)
    res_valid && (outcome == OC_NEXT || outcome == OC_DOWN) |-> retries_now == '0)
    else $error("retry count not cleared");

endmodule

bind stop_and_wait_sender_table swst_chk u_swst_chk (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (result.valid),
  .res_ready   (result.ready),
  .outcome     (result.outcome),
  .tx_seqno    (result.tx_seqno),
  .retries_now (result.retries_now)
);

@@ tb/tb_stop_and_wait_sender_table.sv @@
// Self-checking testbench for the stop-and-wait sender table with a built-in outcome predictor.
module tb_stop_and_wait_sender_table;
  timeunit 1ns;
  timeprecision 1ps;
  import swst_pkg::*;

  localparam int PAIRS       = QUEUE_SLOTS * PEER_SLOTS;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 400;

  // Predicts the outcome of every accepted transaction and matches results against it.
  class arq_scoreboard;
    retry_t  limit;
    seq_t    last_seq[PAIRS];
    bit      last_valid[PAIRS];
    tstamp_t last_stamp[PAIRS];
    retry_t  resend_cnt[PAIRS];
    bit      peer_is_down[PEER_SLOTS];
    result_t outcomes_due[$];
    int      errors;

    function new();
      limit = RETRY_LIMIT_RST;
      foreach (last_seq[i]) begin
        last_seq[i]   = '0;
        last_valid[i] = 1'b0;
        last_stamp[i] = '0;
        resend_cnt[i] = '0;
      end
      foreach (peer_is_down[i]) peer_is_down[i] = 1'b0;
      errors = 0;
    endfunction

    // Apply one accepted transaction to the table copy and queue its outcome.
    function void record_check(item_t it);
      result_t r;
      int      p;
      logic    acked;
      tstamp_t elapsed;
      p = int'(it.queue_index) * PEER_SLOTS + int'(it.member_index);
      r.outcome     = OC_NOTHING;
      r.tx_seqno    = '0;
      r.retries_now = '0;
      if (it.action) begin
        peer_is_down[it.member_index] = 1'b0;
      end else if (peer_is_down[it.member_index]) begin
        r.outcome     = OC_SKIP;
        r.retries_now = resend_cnt[p];
      end else if (!it.newest_valid) begin
        r.retries_now = resend_cnt[p];
      end else begin
        acked = last_valid[p] && it.ack_valid && (last_seq[p] == it.ack_seqno);
        if (acked && last_seq[p] == it.newest_seqno) begin
          r.retries_now = resend_cnt[p];
        end else if (!last_valid[p] || (acked && last_seq[p] < it.newest_seqno)) begin
          // Move on to the next message of the queue.
          last_seq[p]   = last_valid[p] ? last_seq[p] + 1'b1 : '0;
          last_valid[p] = 1'b1;
          last_stamp[p] = it.now_ms;
          resend_cnt[p] = '0;
          r.outcome     = OC_NEXT;
          r.tx_seqno    = last_seq[p];
        end else begin
          elapsed = it.now_ms - last_stamp[p];
          if (!acked && elapsed < (tstamp_t'(it.round_trip) << 1)) begin
            r.outcome     = OC_WAIT;
            r.retries_now = resend_cnt[p];
          end else if (!acked && resend_cnt[p] > limit) begin
            peer_is_down[it.member_index] = 1'b1;
            resend_cnt[p] = '0;
            r.outcome     = OC_DOWN;
          end else begin
            // Timed-out resend, or a resend when the queue fell behind an acked send.
            if (!acked && resend_cnt[p] != '1) resend_cnt[p] = resend_cnt[p] + 1'b1;
            last_stamp[p] = it.now_ms;
            r.outcome     = OC_RETX;
            r.tx_seqno    = last_seq[p];
            r.retries_now = resend_cnt[p];
          end
        end
      end
      outcomes_due.push_back(r);
    endfunction

    // Compare one result transaction with the oldest predicted outcome.
    function void check_result(logic [2:0] oc, seq_t seqno, retry_t retries);
      result_t want;
      if (outcomes_due.size() == 0) begin
        $error("result with no pending check: outcome %0d", oc);
        errors++;
        return;
      end
      want = outcomes_due.pop_front();
      if (oc !== want.outcome) begin
        $error("outcome: expected %0d, got %0d", want.outcome, oc);
        errors++;
      end
      if (seqno !== want.tx_seqno) begin
        $error("tx_seqno: expected %0h, got %0h", want.tx_seqno, seqno);
        errors++;
      end
      if (retries !== want.retries_now) begin
        $error("retries_now: expected %0d, got %0d", want.retries_now, retries);
        errors++;
      end
    endfunction

    function int pending();
      return outcomes_due.size();
    endfunction
  endclass

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   cfg_wr_en;
  retry_t cfg_wr_data;
  bit     hold_results = 1'b0;
  bit     steady = 1'b0;
  int     cycles = 0;

  arq_scoreboard sb = new();

  // Stimulus view of the queues, the peers' acks and the wall clock.
  seq_t       q_newest[QUEUE_SLOTS];
  bit         q_has[QUEUE_SLOTS];
  seq_t       ack_val[PAIRS];
  bit         ack_has[PAIRS];
  tstamp_t    clock_ms = '0;
  logic [1:0] cur_q = '0;
  logic [2:0] cur_m = '0;

  swst_in_if  in_ch();
  swst_out_if out_ch();

  stop_and_wait_sender_table dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item        (in_ch),
    .result      (out_ch)
  );

  always begin
    #4ns clk = 1'b1;
    #4ns clk = 1'b0;
  end

  // Timeout guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Monitor both channels; results are matched before the new transaction is noted.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.outcome, out_ch.tx_seqno, out_ch.retries_now);
      if (in_ch.valid && in_ch.ready)
        sb.record_check({in_ch.action, in_ch.queue_index, in_ch.member_index,
                         in_ch.newest_valid, in_ch.newest_seqno, in_ch.ack_valid,
                         in_ch.ack_seqno, in_ch.round_trip, in_ch.now_ms});
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Result side: random back-pressure plus one long hold-off on request.
  initial begin
    out_ch.ready = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_results) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
        if (pick_gap() > 0) begin
          out_ch.ready <= 1'b0;
          repeat (pick_gap() + 1) @(posedge clk);
        end
      end
    end
  end

  function automatic item_t mk_check(logic [1:0] q, logic [2:0] m, logic nv, seq_t newest,
                                     logic av, seq_t ack, logic [RTT_BITS-1:0] rtt,
                                     tstamp_t now);
    item_t it;
    it.action       = 1'b0;
    it.queue_index  = q;
    it.member_index = m;
    it.newest_valid = nv;
    it.newest_seqno = newest;
    it.ack_valid    = av;
    it.ack_seqno    = ack;
    it.round_trip   = rtt;
    it.now_ms       = now;
    return it;
  endfunction

  function automatic item_t mk_reconnect(logic [2:0] m);
    item_t it;
    it              = '1;
    it.member_index = m;
    return it;
  endfunction

  // Offer one transaction after a random gap and wait until it is taken.
  task automatic offer(input item_t it);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.action       <= it.action;
    in_ch.queue_index  <= it.queue_index;
    in_ch.member_index <= it.member_index;
    in_ch.newest_valid <= it.newest_valid;
    in_ch.newest_seqno <= it.newest_seqno;
    in_ch.ack_valid    <= it.ack_valid;
    in_ch.ack_seqno    <= it.ack_seqno;
    in_ch.round_trip   <= it.round_trip;
    in_ch.now_ms       <= it.now_ms;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stop sending and wait for every outstanding result.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_retry_limit(input retry_t v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    sb.limit = v;
  endtask

  // Random traffic: mostly coherent check sequences per pair, some reconnects and noise.
  task automatic random_checks(input int count, input int ack_pct);
    item_t        it;
    logic [127:0] raw;
    int           r;
    int           p;
    logic [15:0]  rtt;
    for (int i = 0; i < count; i++) begin
      raw = {$urandom(), $urandom(), $urandom(), $urandom()};
      it  = raw[$bits(item_t)-1:0];
      r   = $urandom_range(0, 99);
      if (r < 6) begin
        // Fully random transaction.
      end else if (r < 10) begin
        it.action = 1'b1;
      end else begin
        if ($urandom_range(0, 1)) begin
          cur_q = 2'($urandom_range(0, QUEUE_SLOTS - 1));
          cur_m = 3'($urandom_range(0, PEER_SLOTS - 1));
        end
        p = int'(cur_q) * PEER_SLOTS + int'(cur_m);
        if (sb.peer_is_down[cur_m] && $urandom_range(0, 99) < 40) begin
          it.action       = 1'b1;
          it.member_index = cur_m;
        end else begin
          // The queue grows now and then, and rarely falls behind.
          if ($urandom_range(0, 99) < 25) begin
            if (!q_has[cur_q]) begin
              q_has[cur_q]    = 1'b1;
              q_newest[cur_q] = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFF8 :
                                seq_t'($urandom_range(0, 20));
            end else if (q_newest[cur_q] != '1) begin
              q_newest[cur_q] = q_newest[cur_q] + 1'b1;
            end
          end else if ($urandom_range(0, 99) < 2) begin
            q_newest[cur_q] = q_newest[cur_q] - seq_t'($urandom_range(1, 3));
          end
          // The peer acknowledges the last send with the given likelihood.
          if (sb.last_valid[p] && $urandom_range(0, 99) < ack_pct) begin
            ack_val[p] = sb.last_seq[p];
            ack_has[p] = 1'b1;
          end
          clock_ms = clock_ms + (($urandom_range(0, 99) < 3) ? $urandom() :
                                 $urandom_range(0, 40));
          rtt = ($urandom_range(0, 99) < 5) ? 16'($urandom_range(0, 65535)) :
                16'($urandom_range(0, 15));
          it = mk_check(cur_q, cur_m, q_has[cur_q] && ($urandom_range(0, 19) != 0),
                        q_newest[cur_q], ack_has[p], ack_val[p], rtt, clock_ms);
        end
      end
      offer(it);
    end
  endtask

  // Keep one pair unacknowledged long enough for its retry count to saturate.
  task automatic saturate_retries();
    offer(mk_reconnect(3'd2));
    for (int i = 0; i < 262; i++) begin
      clock_ms = clock_ms + 5;
      offer(mk_check(2'd1, 3'd2, 1'b1, 32'd40, 1'b0, '0, '0, clock_ms));
    end
  endtask

  initial begin
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = '0;
    in_ch.valid        = 1'b0;
    in_ch.action       = 1'b0;
    in_ch.queue_index  = '0;
    in_ch.member_index = '0;
    in_ch.newest_valid = 1'b0;
    in_ch.newest_seqno = '0;
    in_ch.ack_valid    = 1'b0;
    in_ch.ack_seqno    = '0;
    in_ch.round_trip   = '0;
    in_ch.now_ms       = '0;
    foreach (q_newest[i]) begin
      q_newest[i] = '0;
      q_has[i]    = 1'b0;
    end
    foreach (ack_val[i]) begin
      ack_val[i] = '0;
      ack_has[i] = 1'b0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: one pair through send, wait, resends, down and reconnect.
    offer(mk_check(2'd0, 3'd0, 1'b0, 32'd5, 1'b0, '0, 16'd10, 32'd0));
    offer(mk_check(2'd0, 3'd0, 1'b1, 32'd5, 1'b0, '0, 16'd10, 32'd0));
    offer(mk_check(2'd0, 3'd0, 1'b1, 32'd5, 1'b0, '0, 16'd10, 32'd1));
    offer(mk_check(2'd0, 3'd0, 1'b1, 32'd5, 1'b0, '0, 16'd10, 32'd100));
    offer(mk_check(2'd0, 3'd0, 1'b1, 32'd5, 1'b0, '0, 16'd10, 32'd200));
    offer(mk_check(2'd0, 3'd0, 1'b1, 32'd5, 1'b0, '0, 16'd10, 32'd300));
    offer(mk_check(2'd0, 3'd0, 1'b1, 32'd5, 1'b0, '0, 16'd10, 32'd400));
    offer(mk_check(2'd0, 3'd0, 1'b1, 32'd5, 1'b0, '0, 16'd10, 32'd500));
    offer(mk_check(2'd0, 3'd0, 1'b1, 32'd5, 1'b0, '0, 16'd10, 32'd550));
    offer(mk_check(2'd1, 3'd0, 1'b1, 32'd5, 1'b0, '0, 16'd10, 32'd560));
    offer(mk_reconnect(3'd0));
    // Acked progress, caught-up queue, and a queue behind an acked send.
    offer(mk_check(2'd0, 3'd0, 1'b1, 32'd5, 1'b1, 32'd0, 16'd10, 32'd600));
    offer(mk_check(2'd0, 3'd0, 1'b1, 32'd1, 1'b1, 32'd1, 16'd10, 32'd610));
    offer(mk_check(2'd0, 3'd0, 1'b1, 32'd0, 1'b1, 32'd1, 16'd10, 32'd620));
    // Field extremes and time wrapping on the last pair.
    offer(mk_check(2'd3, 3'd7, 1'b1, '1, 1'b0, '1, '1, 32'hFFFF_FFF0));
    offer(mk_check(2'd3, 3'd7, 1'b1, '1, 1'b1, 32'd0, '1, 32'h0000_0010));
    offer(mk_check(2'd3, 3'd7, 1'b1, '1, 1'b0, 32'd0, '1, 32'h0000_0020));
    offer(mk_check(2'd3, 3'd7, 1'b1, '1, 1'b0, 32'd0, '0, 32'h0000_0020));
    offer(mk_reconnect(3'd7));
    random_checks(220, 50);
    drain();

    // Retry limit zero; the result side holds off while checks keep coming.
    set_retry_limit(8'd0);
    hold_results = 1'b1;
    random_checks(180, 40);
    drain();

    // Largest limit: the retry count saturates and the peer is never declared down.
    set_retry_limit(8'd255);
    saturate_retries();
    steady = 1'b1;
    random_checks(100, 30);
    steady = 1'b0;
    drain();

    // A limit just below the largest, with the clock about to wrap.
    set_retry_limit(8'd254);
    clock_ms = 32'hFFFF_F000;
    random_checks(120, 30);
    drain();

    set_retry_limit(retry_t'($urandom_range(1, 10)));
    random_checks(150, 60);
    drain();

    repeat (5) @(posedge clk);
    sb.errors += sb.pending();
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
